// ===== rtl/bts_pkg.sv =====
// bts_pkg: shared constants, types and helper functions of the texture sampler
// used by bts_ctrl, bts_dp, the top level and the checker; depends on nothing
`default_nettype none
package bts_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = XW + YW;
   localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int WORD_W     = 64;
   localparam int CH_W       = 17;
   localparam int RAW_W      = 16;
   localparam int SIZE_W     = 9;
   localparam int T_W        = 26;
   localparam int IN_W       = 136;
   localparam int OUT_W      = 72;
   localparam int CSR_W      = 9;

   localparam logic [SIZE_W-1:0] SIZE_MAX_X = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] SIZE_MAX_Y = SIZE_W'(MAX_HEIGHT);

   typedef enum logic [1:0] {
      OP_STORE    = 2'd0,
      OP_BILINEAR = 2'd1,
      OP_POINT    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_FORMAT = 2'd0,
      REG_BYTES  = 2'd1,
      REG_WIDTH  = 2'd2,
      REG_HEIGHT = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      FMT_R    = 3'd0,
      FMT_RG   = 3'd1,
      FMT_RA   = 3'd2,
      FMT_RGBA = 3'd3,
      FMT_RGBX = 3'd4
   } fmt_type;

   typedef enum logic [1:0] {
      BSEL_TOP  = 2'd0,
      BSEL_BOT  = 2'd1,
      BSEL_VERT = 2'd2
   } bsel_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SPLIT, ST_INDEX, ST_WRITE,
      ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_CAP,
      ST_BL_TOP, ST_BL_BOT, ST_BL_VERT, ST_FINISH
   } state_type;

   typedef logic [CH_W-1:0] chan_type;
   typedef chan_type [3:0] pix_type;

   typedef struct packed {
      logic     valid;
      logic [1:0] idx;
   } slot_type;

   typedef struct packed {
      logic       clear_step;
      logic       load_in;
      logic       split;
      logic       index;
      logic       write;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       blend_en;
      bsel_type   blend_sel;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic   clear_last;
      op_type op;
      logic   out_full;
   } status_type;

   // storage slot of channel ch (r, g, b, a) under format fmt
   function automatic slot_type slot_lookup(input logic [2:0] fmt, input logic [1:0] ch);
      slot_type s;
      s = '0;
      unique case (fmt)
         FMT_R:    if (ch == 2'd0) s = '{1'b1, 2'd0};
         FMT_RG:   if (ch <= 2'd1) s = '{1'b1, ch};
         FMT_RA: begin
            if (ch == 2'd0) s = '{1'b1, 2'd0};
            if (ch == 2'd3) s = '{1'b1, 2'd1};
         end
         FMT_RGBA: s = '{1'b1, ch};
         FMT_RGBX: if (ch <= 2'd2) s = '{1'b1, ch};
         default:  s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [5:0] slot_shift(input logic [1:0] idx, input logic wide);
      return wide ? {idx, 4'd0} : {1'b0, idx, 3'd0};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/bts_ram.sv =====
// bts_ram: generic single-port ram, one access per cycle, registered read
// no dependencies
`default_nettype none
module bts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule
`default_nettype wire

// ===== rtl/bts_ctrl.sv =====
// bts_ctrl: sequencer of the sampler, clear pass, store and sample steps
// depends on bts_pkg
`default_nettype none
module bts_ctrl
   import bts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:    if (req_tvalid) state_in = ST_SPLIT;
         ST_SPLIT: begin
            unique case (status.op)
               OP_STORE:              state_in = ST_WRITE;
               OP_BILINEAR, OP_POINT: state_in = ST_INDEX;
               default:               state_in = ST_IDLE;
            endcase
         end
         ST_WRITE:   state_in = ST_IDLE;
         ST_INDEX:   state_in = ST_RD0;
         ST_RD0:     state_in = ST_RD1;
         ST_RD1:     state_in = ST_RD2;
         ST_RD2:     state_in = ST_RD3;
         ST_RD3:     state_in = ST_CAP;
         ST_CAP:     state_in = ST_BL_TOP;
         ST_BL_TOP:  state_in = ST_BL_BOT;
         ST_BL_BOT:  state_in = ST_BL_VERT;
         ST_BL_VERT: state_in = ST_FINISH;
         ST_FINISH:  if (!status.out_full) state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:   cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_SPLIT:   cmd.split = 1'b1;
         ST_WRITE:   cmd.write = 1'b1;
         ST_INDEX:   cmd.index = 1'b1;
         ST_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = 2'd0;
         end
         ST_RD1: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = 2'd1;
         end
         ST_RD2: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = 2'd2;
         end
         ST_RD3: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = 2'd3;
         end
         ST_CAP:     cmd = '0;
         ST_BL_TOP: begin
            cmd.blend_en  = 1'b1;
            cmd.blend_sel = BSEL_TOP;
         end
         ST_BL_BOT: begin
            cmd.blend_en  = 1'b1;
            cmd.blend_sel = BSEL_BOT;
         end
         ST_BL_VERT: begin
            cmd.blend_en  = 1'b1;
            cmd.blend_sel = BSEL_VERT;
         end
         ST_FINISH:  cmd.load_out = !status.out_full;
         default:    cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/bts_dp.sv =====
// bts_dp: sampler datapath, config registers, coordinate split, pixel memory,
// texel decode, four-lane blend unit and result register; depends on bts_pkg, bts_ram
`default_nettype none
module bts_dp
   import bts_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic [IN_W-1:0]   req_tdata,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [OUT_W-1:0]       rsp_tdata
);

   // configuration
   logic [2:0]        fmt_ff;
   logic              wide_ff;
   logic [SIZE_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_RGBA;
         wide_ff   <= 1'b0;
         width_ff  <= SIZE_MAX_X;
         height_ff <= SIZE_MAX_Y;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FORMAT: fmt_ff    <= csr_wdata[2:0];
            REG_BYTES:  wide_ff   <= (csr_wdata[1:0] >= 2'd2);
            REG_WIDTH:  width_ff  <= csr_wdata;
            REG_HEIGHT: height_ff <= csr_wdata;
            default:    fmt_ff    <= fmt_ff;
         endcase
      end
   end

   logic [SIZE_W-1:0] weff, heff;
   logic [RAW_W-1:0]  cmax;
   assign weff = (width_ff == '0) ? SIZE_W'(1) : (width_ff > SIZE_MAX_X) ? SIZE_MAX_X : width_ff;
   assign heff = (height_ff == '0) ? SIZE_W'(1)
               : (height_ff > SIZE_MAX_Y) ? SIZE_MAX_Y : height_ff;
   assign cmax = wide_ff ? 16'hFFFF : 16'h00FF;

   // input beat
   logic [1:0]       op_ff;
   logic [15:0]      px_ff, py_ff;
   logic [CH_W-1:0]  u_ff, v_ff;
   chan_type [3:0]   cin_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff     <= req_tdata[1:0];
         px_ff     <= req_tdata[17:2];
         py_ff     <= req_tdata[33:18];
         u_ff      <= req_tdata[50:34];
         v_ff      <= req_tdata[67:51];
         cin_ff[0] <= req_tdata[84:68];
         cin_ff[1] <= req_tdata[101:85];
         cin_ff[2] <= req_tdata[118:102];
         cin_ff[3] <= req_tdata[135:119];
      end
   end

   // coordinate split
   logic [T_W-1:0] tx_ff, ty_ff;
   always_ff @(posedge clock) begin
      if (cmd.split) begin
         tx_ff <= T_W'(u_ff) * T_W'(weff) + T_W'(32768);
         ty_ff <= T_W'(v_ff) * T_W'(heff) + T_W'(32768);
      end
   end

   logic [9:0]  bx, by, x0w, x1w, y0w, y1w, xlim, ylim;
   logic [15:0] pxc, pyc;
   assign xlim = 10'(weff) - 10'd1;
   assign ylim = 10'(heff) - 10'd1;
   assign bx   = tx_ff[25:16];
   assign by   = ty_ff[25:16];
   always_comb begin
      x0w = (bx == '0) ? '0 : bx - 10'd1;
      y0w = (by == '0) ? '0 : by - 10'd1;
      if (x0w > xlim) x0w = xlim;
      if (y0w > ylim) y0w = ylim;
      x1w = (bx > xlim) ? xlim : bx;
      y1w = (by > ylim) ? ylim : by;
      pxc = (px_ff > 16'(xlim)) ? 16'(xlim) : px_ff;
      pyc = (py_ff > 16'(ylim)) ? 16'(ylim) : py_ff;
   end

   logic [XW-1:0] x0_ff, x1_ff;
   logic [YW-1:0] y0_ff, y1_ff;
   logic [15:0]   fx_ff, fy_ff;
   always_ff @(posedge clock) begin
      if (cmd.index) begin
         if (op_ff == OP_POINT) begin
            x0_ff <= pxc[XW-1:0];
            x1_ff <= pxc[XW-1:0];
            y0_ff <= pyc[YW-1:0];
            y1_ff <= pyc[YW-1:0];
            fx_ff <= '0;
            fy_ff <= '0;
         end else begin
            x0_ff <= x0w[XW-1:0];
            x1_ff <= x1w[XW-1:0];
            y0_ff <= y0w[YW-1:0];
            y1_ff <= y1w[YW-1:0];
            fx_ff <= tx_ff[15:0];
            fy_ff <= ty_ff[15:0];
         end
      end
   end

   // store word
   logic [WORD_W-1:0] wword;
   logic              store_ok;
   always_comb begin
      logic [32:0]      prod;
      logic [RAW_W-1:0] raw;
      slot_type         s;
      wword = '0;
      for (int c = 0; c < 4; c++) begin
         prod = wide_ff ? ({cin_ff[c], 16'd0} - 33'(cin_ff[c]))
                        : (33'({cin_ff[c], 8'd0}) - 33'(cin_ff[c]));
         raw  = (prod[32:16] > 17'(cmax)) ? cmax : prod[31:16];
         s    = slot_lookup(fmt_ff, 2'(c));
         if (s.valid) wword = wword | (WORD_W'(raw) << slot_shift(s.idx, wide_ff));
      end
      if (fmt_ff == FMT_RGBX) wword = wword | (WORD_W'(cmax) << slot_shift(2'd3, wide_ff));
      store_ok = (px_ff < 16'(weff)) && (py_ff < 16'(heff)) && (fmt_ff <= FMT_RGBX);
   end

   // pixel memory
   logic [ADDR_W-1:0] clr_ff, clr_in, addr;
   logic [WORD_W-1:0] mem_wdata, rdata;
   logic              mem_we;

   assign clr_in = clr_ff + ADDR_W'(1);
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_in;
      end
   end

   always_comb begin
      addr = {y0_ff, x0_ff};
      priority if (cmd.clear_step) begin
         addr = clr_ff;
      end else if (cmd.write) begin
         addr = {py_ff[YW-1:0], px_ff[XW-1:0]};
      end else begin
         unique case (cmd.rd_sel)
            2'd0: addr = {y0_ff, x0_ff};
            2'd1: addr = {y0_ff, x1_ff};
            2'd2: addr = {y1_ff, x0_ff};
            2'd3: addr = {y1_ff, x1_ff};
            default: addr = {y0_ff, x0_ff};
         endcase
      end
   end
   assign mem_we    = cmd.clear_step || (cmd.write && store_ok);
   assign mem_wdata = cmd.clear_step ? '0 : wword;

   bts_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (addr),
      .wdata (mem_wdata),
      .rdata (rdata)
   );

   // texel decode and capture
   logic       rd_pend_ff;
   logic [1:0] rd_idx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
      end
      rd_idx_ff <= cmd.rd_sel;
   end

   pix_type dec;
   always_comb begin
      logic [WORD_W-1:0] sh;
      logic [RAW_W-1:0]  raw;
      slot_type          s;
      for (int c = 0; c < 4; c++) begin
         s   = slot_lookup(fmt_ff, 2'(c));
         sh  = rdata >> slot_shift(s.idx, wide_ff);
         raw = sh[RAW_W-1:0] & cmax;
         if (!s.valid) begin
            dec[c] = '0;
         end else if (wide_ff) begin
            dec[c] = CH_W'(raw) + CH_W'(raw[15]);
         end else begin
            dec[c] = CH_W'({raw[7:0], raw[7:0]}) + CH_W'(raw[7]);
         end
      end
   end

   pix_type tex_ff [4];
   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         tex_ff[rd_idx_ff] <= dec;
      end
   end

   // blend lanes
   pix_type     ba, bb, bres, top_ff, bot_ff, res_ff;
   logic [15:0] bf;
   always_comb begin
      unique case (cmd.blend_sel)
         BSEL_TOP: begin
            ba = tex_ff[0];
            bb = tex_ff[1];
            bf = fx_ff;
         end
         BSEL_BOT: begin
            ba = tex_ff[2];
            bb = tex_ff[3];
            bf = fx_ff;
         end
         default: begin
            ba = top_ff;
            bb = bot_ff;
            bf = fy_ff;
         end
      endcase
   end

   always_comb begin
      logic signed [17:0] diff;
      logic signed [34:0] prod, sum;
      for (int c = 0; c < 4; c++) begin
         diff    = $signed({1'b0, bb[c]}) - $signed({1'b0, ba[c]});
         prod    = 35'(diff) * $signed({19'd0, bf});
         sum     = $signed({2'b00, ba[c], 16'd0}) + prod + 35'sd32768;
         bres[c] = sum[32:16];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.blend_en) begin
         unique case (cmd.blend_sel)
            BSEL_TOP: top_ff <= bres;
            BSEL_BOT: bot_ff <= bres;
            default:  res_ff <= bres;
         endcase
      end
   end

   // result register
   logic            rsp_valid_ff;
   logic [OUT_W-1:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {4'd0, res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tdata         = rsp_data_ff;
   assign status.clear_last = (clr_ff == '1);
   assign status.op         = op_type'(op_ff);
   assign status.out_full   = rsp_valid_ff && !rsp_tready;

endmodule
`default_nettype wire

// ===== rtl/bilinear_texture_sampler_top.sv =====
// bilinear_texture_sampler_top: texture sampler with clamp-to-edge addressing
// depends on bts_pkg, bts_ctrl, bts_dp, bts_ram
//
//  port group | dir | contents
//  req_*      | in  | store, bilinear or point sample command, 136-bit tdata
//  rsp_*      | out | sampled rgba, 72-bit tdata
//  csr_*      | in  | register write: index 0 format, 1 bytes, 2 width, 3 height
//
// after reset the pixel memory is swept to zero, every address, req_tready low
// a store passes split and write states, opcode 3 only the split state; a sample
// passes split, index, four texel reads through the single memory port, a capture
// state, then three passes of the four-lane blend unit, and a finish state
// a held result does not stall the next command until its own result is due
`default_nettype none
module bilinear_texture_sampler_top
   import bts_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // opcode, pixel_x, pixel_y, u_coord, v_coord, red_in, green_in, blue_in, alpha_in
   input  wire logic [IN_W-1:0]   req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // red_out, green_out, blue_out, alpha_out, zero fill
   output logic [OUT_W-1:0]       rsp_tdata,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bts_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== rtl/bts_checker.sv =====
// bts_checker: port-level assertions for the sampler, bound to the top level
// depends on bts_pkg
`default_nettype none
module bts_checker
   import bts_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [OUT_W-1:0]  rsp_tdata
);

   // clear pass holds off commands
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("req_tready high right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp beat changed");

   // results never appear the cycle after a command beat
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result without sample latency");

   a_red_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:0] <= 17'd65536 && rsp_tdata[71:68] == 4'd0)
      else $error("red out of range");

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:51] <= 17'd65536)
      else $error("alpha out of range");

endmodule

bind bilinear_texture_sampler_top bts_checker u_bts_checker (.*);
`default_nettype wire
